FILE: design/stscan_pkg.sv
// Shared types, token codes and character tables for the source token scanner.
`default_nettype none
package stscan_pkg;

    localparam int unsigned LINE_WIDTH_DEF   = 16;
    localparam int unsigned COLUMN_WIDTH_DEF = 16;
    localparam int unsigned OFFSET_WIDTH_DEF = 32;
    localparam int unsigned LENGTH_WIDTH_DEF = 16;
    localparam int unsigned MAX_RESULTS      = 3;

    typedef logic [4:0]  kind_t;
    typedef logic [15:0] line_t;
    typedef logic [15:0] column_t;
    typedef logic [31:0] offset_t;
    typedef logic [15:0] length_t;
    typedef logic [5:0]  kw_mask_t;
    typedef logic [1:0]  res_cnt_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_INT   = 3'd1,
        MODE_FLOAT = 3'd2,
        MODE_DOT   = 3'd3,
        MODE_MINUS = 3'd4,
        MODE_WORD  = 3'd5
    } mode_t;

    localparam kind_t KIND_INT    = 5'd0;
    localparam kind_t KIND_FLOAT  = 5'd1;
    localparam kind_t KIND_PLUS   = 5'd2;
    localparam kind_t KIND_MINUS  = 5'd3;
    localparam kind_t KIND_STAR   = 5'd4;
    localparam kind_t KIND_SLASH  = 5'd5;
    localparam kind_t KIND_LPAREN = 5'd6;
    localparam kind_t KIND_RPAREN = 5'd7;
    localparam kind_t KIND_SEMI   = 5'd8;
    localparam kind_t KIND_COLON  = 5'd9;
    localparam kind_t KIND_EQUAL  = 5'd10;
    localparam kind_t KIND_COMMA  = 5'd11;
    localparam kind_t KIND_ARROW  = 5'd12;
    localparam kind_t KIND_LBRACE = 5'd13;
    localparam kind_t KIND_RBRACE = 5'd14;
    localparam kind_t KIND_KEY0   = 5'd15;
    localparam kind_t KIND_IDENT  = 5'd21;
    localparam kind_t KIND_END    = 5'd22;
    localparam kind_t KIND_ERROR  = 5'd23;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_US    = 8'h5F;

    localparam int unsigned KW_COUNT = 6;
    localparam kw_mask_t    KW_ALL   = 6'h3F;
    localparam logic [47:0] KW_TEXT [KW_COUNT] =
        '{"return", "const", "mut", "int", "float", "fn"};
    localparam logic [2:0]  KW_LEN [KW_COUNT] =
        '{3'd6, 3'd5, 3'd3, 3'd3, 3'd5, 3'd2};

    typedef struct packed {
        kind_t   kind;
        line_t   line;
        column_t column;
        offset_t offset;
        length_t length;
        logic    run_end;
    } res_t;

    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        res_cnt_t               cnt;
    } bundle_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } sign_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_US);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic sign_t single_sign(logic [7:0] c);
        sign_t s;
        s.hit = 1'b1;
        case (c)
            8'h2B:   s.kind = KIND_PLUS;
            8'h2A:   s.kind = KIND_STAR;
            8'h2F:   s.kind = KIND_SLASH;
            8'h28:   s.kind = KIND_LPAREN;
            8'h29:   s.kind = KIND_RPAREN;
            8'h3B:   s.kind = KIND_SEMI;
            8'h3A:   s.kind = KIND_COLON;
            8'h3D:   s.kind = KIND_EQUAL;
            8'h2C:   s.kind = KIND_COMMA;
            8'h7B:   s.kind = KIND_LBRACE;
            8'h7D:   s.kind = KIND_RBRACE;
            default: begin
                s.hit  = 1'b0;
                s.kind = KIND_ERROR;
            end
        endcase
        return s;
    endfunction

    // keep keywords whose character at pos equals c
    function automatic kw_mask_t kw_narrow(kw_mask_t mask, logic [7:0] c,
                                           logic [2:0] pos, logic pos_ok);
        kw_mask_t    r;
        logic [47:0] txt;
        int          sh;
        r = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            txt = KW_TEXT[k];
            sh  = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
            if (sh < 0) begin
                sh = 0;
            end
            if (mask[k] && pos_ok && (pos < KW_LEN[k]) && (txt[sh +: 8] == c)) begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/stscan_lexer.sv
// Scanner state and per-byte token logic; yields a bundle of up to three results per item.
`default_nettype none
module stscan_lexer #(
    parameter int unsigned LINE_WIDTH   = stscan_pkg::LINE_WIDTH_DEF,
    parameter int unsigned COLUMN_WIDTH = stscan_pkg::COLUMN_WIDTH_DEF,
    parameter int unsigned OFFSET_WIDTH = stscan_pkg::OFFSET_WIDTH_DEF,
    parameter int unsigned LENGTH_WIDTH = stscan_pkg::LENGTH_WIDTH_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   accept,
    input  wire  [7:0]            source_byte,
    input  wire                   byte_present,
    input  wire                   final_item,
    output logic                  push,
    output stscan_pkg::bundle_t   bundle
);

    stscan_pkg::mode_t        mode_reg, mode_next;
    stscan_pkg::kw_mask_t     kc_reg, kc_next;
    logic [LINE_WIDTH-1:0]    cur_line_reg, cur_line_next;
    logic [COLUMN_WIDTH-1:0]  cur_col_reg, cur_col_next;
    logic [OFFSET_WIDTH-1:0]  cur_off_reg, cur_off_next;
    logic [LINE_WIDTH-1:0]    pend_line_reg, pend_line_next;
    logic [COLUMN_WIDTH-1:0]  pend_col_reg, pend_col_next;
    logic [OFFSET_WIDTH-1:0]  pend_off_reg, pend_off_next;
    logic [LENGTH_WIDTH-1:0]  pend_len_reg, pend_len_next;

    stscan_pkg::bundle_t      bnd;
    stscan_pkg::res_cnt_t     n;
    stscan_pkg::sign_t        sgn;
    logic                     used;

    function automatic stscan_pkg::res_t mk_res(
        stscan_pkg::kind_t kind, logic [LINE_WIDTH-1:0] line,
        logic [COLUMN_WIDTH-1:0] col, logic [OFFSET_WIDTH-1:0] off,
        logic [LENGTH_WIDTH-1:0] len);
        stscan_pkg::res_t r;
        r.kind    = kind;
        r.line    = stscan_pkg::line_t'(line);
        r.column  = stscan_pkg::column_t'(col);
        r.offset  = stscan_pkg::offset_t'(off);
        r.length  = stscan_pkg::length_t'(len);
        r.run_end = 1'b0;
        return r;
    endfunction

    function automatic stscan_pkg::kind_t flush_kind(stscan_pkg::mode_t m,
                                                     stscan_pkg::kw_mask_t kc,
                                                     logic [LENGTH_WIDTH-1:0] len);
        stscan_pkg::kind_t k;
        k = stscan_pkg::KIND_ERROR;
        unique case (m)
            stscan_pkg::MODE_INT:   k = stscan_pkg::KIND_INT;
            stscan_pkg::MODE_FLOAT: k = stscan_pkg::KIND_FLOAT;
            stscan_pkg::MODE_DOT:   k = stscan_pkg::KIND_ERROR;
            stscan_pkg::MODE_MINUS: k = stscan_pkg::KIND_MINUS;
            stscan_pkg::MODE_WORD: begin
                k = stscan_pkg::KIND_IDENT;
                // lowest keyword index wins
                for (int i = stscan_pkg::KW_COUNT - 1; i >= 0; i--) begin
                    if (kc[i] && (len == LENGTH_WIDTH'(stscan_pkg::KW_LEN[i]))) begin
                        k = stscan_pkg::kind_t'(stscan_pkg::KIND_KEY0 + 5'(i));
                    end
                end
            end
            default: k = stscan_pkg::KIND_ERROR;
        endcase
        return k;
    endfunction

    always_comb begin
        mode_next      = mode_reg;
        kc_next        = kc_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        cur_off_next   = cur_off_reg;
        pend_line_next = pend_line_reg;
        pend_col_next  = pend_col_reg;
        pend_off_next  = pend_off_reg;
        pend_len_next  = pend_len_reg;
        bnd            = '0;
        n              = '0;
        used           = 1'b0;
        sgn            = stscan_pkg::single_sign(source_byte);

        if (byte_present) begin
            unique case (mode_next)
                stscan_pkg::MODE_INT: begin
                    if (stscan_pkg::is_digit(source_byte)) begin
                        used = 1'b1;
                    end else if (source_byte == stscan_pkg::CH_DOT) begin
                        used      = 1'b1;
                        mode_next = stscan_pkg::MODE_FLOAT;
                    end
                end
                stscan_pkg::MODE_FLOAT: begin
                    used = stscan_pkg::is_digit(source_byte);
                end
                stscan_pkg::MODE_DOT: begin
                    if (stscan_pkg::is_digit(source_byte)) begin
                        used      = 1'b1;
                        mode_next = stscan_pkg::MODE_FLOAT;
                    end
                end
                stscan_pkg::MODE_MINUS: begin
                    if (source_byte == stscan_pkg::CH_GT) begin
                        bnd.res[n] = mk_res(stscan_pkg::KIND_ARROW, pend_line_next,
                                            pend_col_next, pend_off_next,
                                            LENGTH_WIDTH'(2));
                        n         = n + 2'd1;
                        mode_next = stscan_pkg::MODE_IDLE;
                        used      = 1'b1;
                    end
                end
                stscan_pkg::MODE_WORD: begin
                    if (stscan_pkg::is_word(source_byte)) begin
                        kc_next = stscan_pkg::kw_narrow(kc_next, source_byte,
                                      pend_len_next[2:0],
                                      (pend_len_next >> 3) == '0);
                        used = 1'b1;
                    end
                end
                default: mode_next = stscan_pkg::MODE_IDLE;
            endcase

            // arrow consumes the byte without growing the pending token
            if (used && (mode_next != stscan_pkg::MODE_IDLE)) begin
                pend_len_next = (pend_len_next == '1) ? pend_len_next
                                                      : pend_len_next + 1'b1;
            end

            if (!used) begin
                if (mode_next != stscan_pkg::MODE_IDLE) begin
                    bnd.res[n] = mk_res(flush_kind(mode_next, kc_next, pend_len_next),
                                        pend_line_next, pend_col_next, pend_off_next,
                                        pend_len_next);
                    n = n + 2'd1;
                end
                mode_next = stscan_pkg::MODE_IDLE;
                kc_next   = stscan_pkg::KW_ALL;

                if (stscan_pkg::is_space(source_byte)) begin
                    mode_next = stscan_pkg::MODE_IDLE;
                end else if (stscan_pkg::is_digit(source_byte) ||
                             (source_byte == stscan_pkg::CH_DOT) ||
                             (source_byte == stscan_pkg::CH_MINUS) ||
                             stscan_pkg::is_alpha(source_byte) ||
                             (source_byte == stscan_pkg::CH_US)) begin
                    pend_line_next = cur_line_reg;
                    pend_col_next  = cur_col_reg;
                    pend_off_next  = cur_off_reg;
                    pend_len_next  = LENGTH_WIDTH'(1);
                    if (stscan_pkg::is_digit(source_byte)) begin
                        mode_next = stscan_pkg::MODE_INT;
                    end else if (source_byte == stscan_pkg::CH_DOT) begin
                        mode_next = stscan_pkg::MODE_DOT;
                    end else if (source_byte == stscan_pkg::CH_MINUS) begin
                        mode_next = stscan_pkg::MODE_MINUS;
                    end else begin
                        mode_next = stscan_pkg::MODE_WORD;
                        kc_next   = stscan_pkg::kw_narrow(stscan_pkg::KW_ALL,
                                        source_byte, 3'd0, 1'b1);
                    end
                end else begin
                    bnd.res[n] = mk_res(sgn.hit ? sgn.kind : stscan_pkg::KIND_ERROR,
                                        cur_line_reg, cur_col_reg, cur_off_reg,
                                        LENGTH_WIDTH'(1));
                    n = n + 2'd1;
                end
            end

            if (source_byte == stscan_pkg::CH_LF) begin
                cur_line_next = (cur_line_reg == '1) ? cur_line_reg : cur_line_reg + 1'b1;
                cur_col_next  = '0;
            end else begin
                cur_col_next = (cur_col_reg == '1) ? cur_col_reg : cur_col_reg + 1'b1;
            end
            cur_off_next = (cur_off_reg == '1) ? cur_off_reg : cur_off_reg + 1'b1;
        end

        if (final_item) begin
            if (mode_next != stscan_pkg::MODE_IDLE) begin
                bnd.res[n] = mk_res(flush_kind(mode_next, kc_next, pend_len_next),
                                    pend_line_next, pend_col_next, pend_off_next,
                                    pend_len_next);
                n = n + 2'd1;
            end
            bnd.res[n] = mk_res(stscan_pkg::KIND_END, cur_line_next, cur_col_next,
                                cur_off_next, '0);
            n = n + 2'd1;
            mode_next      = stscan_pkg::MODE_IDLE;
            kc_next        = stscan_pkg::KW_ALL;
            cur_line_next  = '0;
            cur_col_next   = '0;
            cur_off_next   = '0;
            pend_line_next = '0;
            pend_col_next  = '0;
            pend_off_next  = '0;
            pend_len_next  = '0;
        end

        if (n != '0) begin
            bnd.res[n - 2'd1].run_end = 1'b1;
        end
        bnd.cnt = n;
    end

    assign push   = accept && (n != '0);
    assign bundle = bnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= stscan_pkg::MODE_IDLE;
            kc_reg        <= stscan_pkg::KW_ALL;
            cur_line_reg  <= '0;
            cur_col_reg   <= '0;
            cur_off_reg   <= '0;
            pend_line_reg <= '0;
            pend_col_reg  <= '0;
            pend_off_reg  <= '0;
            pend_len_reg  <= '0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            kc_reg        <= kc_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            cur_off_reg   <= cur_off_next;
            pend_line_reg <= pend_line_next;
            pend_col_reg  <= pend_col_next;
            pend_off_reg  <= pend_off_next;
            pend_len_reg  <= pend_len_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/stscan_outq.sv
// Two-entry queue of result bundles, drained one result per output handshake.
`default_nettype none
module stscan_outq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  stscan_pkg::bundle_t  bundle,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output stscan_pkg::res_t     out_res
);

    stscan_pkg::bundle_t   q_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            cnt_reg, cnt_next;
    stscan_pkg::res_cnt_t  idx_reg, idx_next;
    stscan_pkg::bundle_t   head;
    logic                  take, pop;

    assign head      = q_reg[rd_ptr_reg];
    assign out_valid = cnt_reg != 2'd0;
    assign in_ready  = cnt_reg != 2'd2;
    assign out_res   = head.res[idx_reg];
    assign take      = out_valid && out_ready;
    assign pop       = take && (idx_reg == head.cnt - 2'd1);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
        idx_next    = pop ? '0 : (take ? idx_reg + 2'd1 : idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= bundle;
        end
    end

endmodule
`default_nettype wire

FILE: design/source_token_scanner_core.sv
// Top level of the source token scanner: byte-in, token-out lexer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------------
//  s_      | in  | s_valid / s_ready   | source_byte, byte_present, final_item
//  m_      | out | m_valid / m_ready   | token_kind, start_line, start_column,
//          |     |                     | start_offset, token_length, run_end
//
//  One byte is taken per cycle while s_ready is high; its up to three tokens go into a
//  two-entry bundle queue and leave one per cycle while m_ready is high, so the sustained
//  rate is one item per cycle while items average at most one token. Input stalls only
//  while the queue holds two bundles. Synchronous active-low reset clears scanner state
//  and the queue; no clearing pass.
`default_nettype none
module source_token_scanner_core #(
    parameter int unsigned LINE_WIDTH   = stscan_pkg::LINE_WIDTH_DEF,
    parameter int unsigned COLUMN_WIDTH = stscan_pkg::COLUMN_WIDTH_DEF,
    parameter int unsigned OFFSET_WIDTH = stscan_pkg::OFFSET_WIDTH_DEF,
    parameter int unsigned LENGTH_WIDTH = stscan_pkg::LENGTH_WIDTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_source_byte,
    input  wire         s_byte_present,
    input  wire         s_final_item,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [4:0]  m_token_kind,
    output logic [15:0] m_start_line,
    output logic [15:0] m_start_column,
    output logic [31:0] m_start_offset,
    output logic [15:0] m_token_length,
    output logic        m_run_end
);

    stscan_pkg::bundle_t bundle;
    stscan_pkg::res_t    res;
    logic                push;
    logic                accept;

    assign accept = s_valid && s_ready;

    stscan_lexer #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .source_byte  (s_source_byte),
        .byte_present (s_byte_present),
        .final_item   (s_final_item),
        .push         (push),
        .bundle       (bundle)
    );

    stscan_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .bundle    (bundle),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_token_kind   = res.kind;
    assign m_start_line   = res.line;
    assign m_start_column = res.column;
    assign m_start_offset = res.offset;
    assign m_token_length = res.length;
    assign m_run_end      = res.run_end;

endmodule
`default_nettype wire

FILE: test/tb_source_token_scanner_core.sv
// Testbench for source_token_scanner_core: random byte streams checked against a token predictor.
`timescale 1ns / 100ps
module tb_source_token_scanner_core;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    class token_scoreboard;
        stscan_pkg::res_t     expected_tokens[$];
        stscan_pkg::res_t     found[$];
        int unsigned          mismatch_count;
        string                keyword_word[stscan_pkg::KW_COUNT];
        stscan_pkg::mode_t    mode;
        stscan_pkg::line_t    cur_line;
        stscan_pkg::column_t  cur_col;
        stscan_pkg::offset_t  cur_off;
        stscan_pkg::line_t    tok_line;
        stscan_pkg::column_t  tok_col;
        stscan_pkg::offset_t  tok_off;
        stscan_pkg::length_t  tok_len;
        stscan_pkg::kw_mask_t kw_live;

        function new();
            keyword_word = '{"return", "const", "mut", "int", "float", "fn"};
            mismatch_count = 0;
            restart();
        endfunction

        function void restart();
            mode = stscan_pkg::MODE_IDLE;
            cur_line = '0;
            cur_col = '0;
            cur_off = '0;
            tok_line = '0;
            tok_col = '0;
            tok_off = '0;
            tok_len = '0;
            kw_live = stscan_pkg::KW_ALL;
        endfunction

        function logic is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function logic is_name(logic [7:0] c);
            return is_letter(c) || is_num(c) || c == stscan_pkg::CH_US;
        endfunction

        function logic is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function stscan_pkg::kind_t sign_kind(logic [7:0] c);
            case (c)
                "+": return stscan_pkg::KIND_PLUS;
                "*": return stscan_pkg::KIND_STAR;
                "/": return stscan_pkg::KIND_SLASH;
                "(": return stscan_pkg::KIND_LPAREN;
                ")": return stscan_pkg::KIND_RPAREN;
                ";": return stscan_pkg::KIND_SEMI;
                ":": return stscan_pkg::KIND_COLON;
                "=": return stscan_pkg::KIND_EQUAL;
                ",": return stscan_pkg::KIND_COMMA;
                "{": return stscan_pkg::KIND_LBRACE;
                "}": return stscan_pkg::KIND_RBRACE;
                default: return stscan_pkg::KIND_ERROR;
            endcase
        endfunction

        function stscan_pkg::kw_mask_t keep_keywords(stscan_pkg::kw_mask_t m, logic [7:0] c,
                                                     stscan_pkg::length_t pos);
            stscan_pkg::kw_mask_t r;
            r = '0;
            for (int k = 0; k < stscan_pkg::KW_COUNT; k++) begin
                if (m[k] && pos < keyword_word[k].len() && keyword_word[k][pos] == c) begin
                    r[k] = 1'b1;
                end
            end
            return r;
        endfunction

        function void add_token(stscan_pkg::kind_t k, stscan_pkg::line_t l,
                                stscan_pkg::column_t c, stscan_pkg::offset_t o,
                                stscan_pkg::length_t n);
            stscan_pkg::res_t r;
            r.kind = k;
            r.line = l;
            r.column = c;
            r.offset = o;
            r.length = n;
            r.run_end = 1'b0;
            found = {found, r};
        endfunction

        function void start_token(stscan_pkg::mode_t m);
            mode = m;
            tok_line = cur_line;
            tok_col = cur_col;
            tok_off = cur_off;
            tok_len = stscan_pkg::length_t'(1);
        endfunction

        function void grow();
            if (tok_len != '1) begin
                tok_len++;
            end
        endfunction

        function void close_token();
            stscan_pkg::kind_t tk;
            if (mode == stscan_pkg::MODE_IDLE) begin
                kw_live = stscan_pkg::KW_ALL;
                return;
            end
            case (mode)
                stscan_pkg::MODE_INT:   tk = stscan_pkg::KIND_INT;
                stscan_pkg::MODE_FLOAT: tk = stscan_pkg::KIND_FLOAT;
                stscan_pkg::MODE_MINUS: tk = stscan_pkg::KIND_MINUS;
                stscan_pkg::MODE_WORD: begin
                    tk = stscan_pkg::KIND_IDENT;
                    for (int k = 0; k < stscan_pkg::KW_COUNT; k++) begin
                        if (kw_live[k] && keyword_word[k].len() == tok_len) begin
                            tk = stscan_pkg::kind_t'(stscan_pkg::KIND_KEY0 + k);
                            break;
                        end
                    end
                end
                default:    tk = stscan_pkg::KIND_ERROR;
            endcase
            add_token(tk, tok_line, tok_col, tok_off, tok_len);
            mode = stscan_pkg::MODE_IDLE;
            kw_live = stscan_pkg::KW_ALL;
        endfunction

        function void predict_tokens(logic [7:0] c, logic present, logic closing);
            logic used;
            found.delete();
            if (present) begin
                used = 1'b0;
                case (mode)
                    stscan_pkg::MODE_INT: begin
                        if (is_num(c)) begin
                            grow();
                            used = 1'b1;
                        end else if (c == stscan_pkg::CH_DOT) begin
                            grow();
                            mode = stscan_pkg::MODE_FLOAT;
                            used = 1'b1;
                        end
                    end
                    stscan_pkg::MODE_FLOAT: begin
                        if (is_num(c)) begin
                            grow();
                            used = 1'b1;
                        end
                    end
                    stscan_pkg::MODE_DOT: begin
                        if (is_num(c)) begin
                            grow();
                            mode = stscan_pkg::MODE_FLOAT;
                            used = 1'b1;
                        end
                    end
                    stscan_pkg::MODE_MINUS: begin
                        if (c == stscan_pkg::CH_GT) begin
                            add_token(stscan_pkg::KIND_ARROW, tok_line, tok_col, tok_off,
                                      stscan_pkg::length_t'(2));
                            mode = stscan_pkg::MODE_IDLE;
                            used = 1'b1;
                        end
                    end
                    stscan_pkg::MODE_WORD: begin
                        if (is_name(c)) begin
                            kw_live = keep_keywords(kw_live, c, tok_len);
                            grow();
                            used = 1'b1;
                        end
                    end
                    default: mode = stscan_pkg::MODE_IDLE;
                endcase
                if (!used) begin
                    close_token();
                    if (!is_blank(c)) begin
                        if (is_num(c)) begin
                            start_token(stscan_pkg::MODE_INT);
                        end else if (c == stscan_pkg::CH_DOT) begin
                            start_token(stscan_pkg::MODE_DOT);
                        end else if (c == stscan_pkg::CH_MINUS) begin
                            start_token(stscan_pkg::MODE_MINUS);
                        end else if (is_letter(c) || c == stscan_pkg::CH_US) begin
                            start_token(stscan_pkg::MODE_WORD);
                            kw_live = keep_keywords(stscan_pkg::KW_ALL, c, '0);
                        end else begin
                            add_token(sign_kind(c), cur_line, cur_col, cur_off,
                                      stscan_pkg::length_t'(1));
                        end
                    end
                end
                if (c == stscan_pkg::CH_LF) begin
                    if (cur_line != '1) begin
                        cur_line++;
                    end
                    cur_col = '0;
                end else if (cur_col != '1) begin
                    cur_col++;
                end
                if (cur_off != '1) begin
                    cur_off++;
                end
            end
            if (closing) begin
                close_token();
                add_token(stscan_pkg::KIND_END, cur_line, cur_col, cur_off, '0);
                restart();
            end
            if (found.size() != 0) begin
                found[found.size() - 1].run_end = 1'b1;
            end
            foreach (found[i]) begin
                expected_tokens = {expected_tokens, found[i]};
            end
        endfunction

        function void check_token(stscan_pkg::kind_t k, stscan_pkg::line_t l,
                                  stscan_pkg::column_t c, stscan_pkg::offset_t o,
                                  stscan_pkg::length_t n, logic e);
            stscan_pkg::res_t want;
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: kind %0d offset %0d", k, o);
                mismatch_count++;
                return;
            end
            want = expected_tokens.pop_front();
            if (k !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, k);
                mismatch_count++;
            end
            if (l !== want.line) begin
                $error("start_line: expected %0d, got %0d", want.line, l);
                mismatch_count++;
            end
            if (c !== want.column) begin
                $error("start_column: expected %0d, got %0d", want.column, c);
                mismatch_count++;
            end
            if (o !== want.offset) begin
                $error("start_offset: expected %0d, got %0d", want.offset, o);
                mismatch_count++;
            end
            if (n !== want.length) begin
                $error("token_length: expected %0d, got %0d", want.length, n);
                mismatch_count++;
            end
            if (e !== want.run_end) begin
                $error("run_end: expected %0d, got %0d", want.run_end, e);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [7:0]  s_source_byte = '0;
    logic        s_byte_present = 1'b0;
    logic        s_final_item = 1'b0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [4:0]  m_token_kind;
    wire  [15:0] m_start_line;
    wire  [15:0] m_start_column;
    wire  [31:0] m_start_offset;
    wire  [15:0] m_token_length;
    wire         m_run_end;

    token_scoreboard sb;
    int unsigned     send_idle_pct = 26;
    int unsigned     recv_idle_pct = 66;
    int unsigned     quiet_cycles = 0;
    logic [7:0]      fragment[$];
    string           sign_chars = "+-*/();:=,{}";

    source_token_scanner_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_byte  (s_source_byte),
        .s_byte_present (s_byte_present),
        .s_final_item   (s_final_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_start_line   (m_start_line),
        .m_start_column (m_start_column),
        .m_start_offset (m_start_offset),
        .m_token_length (m_token_length),
        .m_run_end      (m_run_end)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.predict_tokens(s_source_byte, s_byte_present, s_final_item);
            end
            if (m_valid && m_ready) begin
                sb.check_token(m_token_kind, m_start_line, m_start_column, m_start_offset,
                               m_token_length, m_run_end);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input logic present, input logic closing);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_source_byte <= b;
        s_byte_present <= present;
        s_final_item <= closing;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            push_item(t[i], 1'b1, 1'b0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_tokens.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic void frag_add(logic [7:0] b);
        fragment = {fragment, b};
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] name_char();
        int unsigned r;
        r = $urandom_range(62);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r < 62) begin
            return 8'(CH_ZERO + r - 52);
        end
        return stscan_pkg::CH_US;
    endfunction

    function automatic void build_fragment();
        int unsigned pick;
        int unsigned k;
        int unsigned v;
        string       w;
        fragment.delete();
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(4, 1)) frag_add(digit_char());
        end else if (pick < 25) begin
            k = $urandom_range(2);
            if (k != 2) begin
                repeat ($urandom_range(3, 1)) frag_add(digit_char());
            end
            frag_add(stscan_pkg::CH_DOT);
            if (k != 1) begin
                repeat ($urandom_range(3, 1)) frag_add(digit_char());
            end
        end else if (pick < 40) begin
            k = $urandom_range(sign_chars.len());
            if (k == sign_chars.len()) begin
                frag_add(stscan_pkg::CH_MINUS);
                frag_add(stscan_pkg::CH_GT);
            end else begin
                frag_add(sign_chars[k]);
            end
        end else if (pick < 55) begin
            w = sb.keyword_word[$urandom_range(stscan_pkg::KW_COUNT - 1)];
            for (int i = 0; i < w.len(); i++) begin
                frag_add(w[i]);
            end
            v = $urandom_range(9);
            if (v == 7) begin
                void'(fragment.pop_back());
            end else if (v == 8) begin
                frag_add(name_char());
            end else if (v == 9) begin
                fragment[0] = fragment[0] ^ CASE_BIT;
            end
        end else if (pick < 68) begin
            k = $urandom_range(52);
            frag_add(k < 26 ? 8'("a" + k) : k < 52 ? 8'("A" + k - 26) : stscan_pkg::CH_US);
            repeat ($urandom_range(6)) frag_add(name_char());
        end else if (pick < 85) begin
            repeat ($urandom_range(3, 1)) frag_add(BLANKS[$urandom_range(5)]);
        end else if (pick < 93) begin
            repeat ($urandom_range(2, 1)) frag_add(8'($urandom_range(255)));
        end else begin
            frag_add($urandom_range(1) ? stscan_pkg::CH_DOT : stscan_pkg::CH_GT);
            if ($urandom_range(1)) begin
                frag_add(8'("a" + $urandom_range(25)));
            end
        end
    endfunction

    task automatic run_random(input int unsigned target);
        int unsigned sent;
        int unsigned r;
        logic        with_end;
        sent = 0;
        while (sent < target) begin
            build_fragment();
            r = $urandom_range(99);
            if (r < 3) begin
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            with_end = (r >= 3 && r < 6);
            foreach (fragment[i]) begin
                push_item(fragment[i], 1'b1, with_end && (i == fragment.size() - 1));
                sent++;
            end
            if (r >= 6 && r < 8) begin
                push_item(8'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
        push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 66;
        send_text("fn _a9->-.5 7.\n.x");
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(stscan_pkg::CH_MINUS, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        send_text("ab");
        push_item(";", 1'b1, 1'b1);
        drain_results();
        run_random(80);
        drain_results();

        send_idle_pct = 66;
        recv_idle_pct = 26;
        run_random(85);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(85);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

FILE: source_token_scanner_core.f
design/stscan_pkg.sv
design/stscan_lexer.sv
design/stscan_outq.sv
design/source_token_scanner_core.sv
test/tb_source_token_scanner_core.sv
